[sv/bbcd_pkg.sv]
// Shared constants, types and helpers for the binary to BCD digit emitter.
// Used by the shift-add-3 converter and by the top-level sequencer.
`default_nettype none
package bbcd_pkg;

    localparam int VALUE_W    = 32;
    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int IDX_W      = 4;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int ITER_W     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

    // A count of zero shows one digit; counts above the display width saturate.
    function automatic logic [IDX_W-1:0] clamp_count(input logic [IDX_W-1:0] c);
        logic [IDX_W-1:0] r;
        begin
            if (c == '0)
            begin
                r = IDX_W'(1);
            end
            else if (c > IDX_W'(MAX_DIGITS))
            begin
                r = IDX_W'(MAX_DIGITS);
            end
            else
            begin
                r = c;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[sv/bbcd_dabble.sv]
// Iterative shift-add-3 converter: one bit of the binary word per cycle.
// Depends on bbcd_pkg for widths and the status struct.
`default_nettype none
module bbcd_dabble
    import bbcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] bin_in,
    output      conv_status_t          status,
    output      logic [BCD_W-1:0]      bcd
);

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(VALUE_BITS - 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic [ITER_W-1:0]     iter_reg;
    logic [ITER_W-1:0]     iter_next;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BCD_W-1:0]      adj;
    logic                  last_iter;

    always_comb
    begin
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
            begin
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            else
            begin
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign last_iter = busy_reg && (iter_reg == LAST_ITER);

    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            bin_next  = bin_in;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
            bin_next  = {bin_reg[VALUE_BITS-2:0], 1'b0};
            iter_next = iter_reg + ITER_W'(1);
            if (last_iter)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = last_iter;
    assign bcd         = bcd_reg;

endmodule
`default_nettype wire

[sv/binary_to_bcd_digit_emitter.sv]
// Top level: accepts a word, converts it in bbcd_dabble, emits digits MSB first.
// The word is converted in bbcd_dabble; ST_EMIT then loads digits into the
// output register, one digit per cycle while out_ready does not stall them.
// A new word is accepted only in ST_IDLE, once the last digit has been loaded.
// Reset: asynchronous active low; count_reg returns to 3, nothing is pending.
`default_nettype none
module binary_to_bcd_digit_emitter
    import bbcd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [VALUE_W-1:0] value,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [DIGIT_W-1:0] bcd_digit,
    output      logic [IDX_W-1:0]   display_index,
    output      logic               last_digit,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_data
);

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     count_reg;
    logic [IDX_W-1:0]     n_reg;
    logic [IDX_W-1:0]     n_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DIGIT_W-1:0]   digit_reg;
    logic [DIGIT_W-1:0]   digit_next;
    logic [IDX_W-1:0]     index_reg;
    logic [IDX_W-1:0]     index_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 start;
    conv_status_t         conv_status;
    logic [BCD_W-1:0]     bcd;
    logic [IDX_W-1:0]     pos;
    logic [DIGIT_W-1:0]   sel_digit;
    logic                 slot_free;

    bbcd_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .bin_in (value[VALUE_BITS-1:0]),
        .status (conv_status),
        .bcd    (bcd)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign start     = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign pos       = n_reg - idx_reg - IDX_W'(1);

    always_comb
    begin
        sel_digit = '0;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (pos == IDX_W'(k))
            begin
                sel_digit = bcd[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        digit_next     = digit_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = clamp_count(count_reg);
                    idx_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_status.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = sel_digit;
                    index_next     = idx_reg;
                    last_next      = (idx_reg == n_reg - IDX_W'(1));
                    idx_next       = idx_reg + IDX_W'(1);
                    if (idx_reg == n_reg - IDX_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_RESET;
            n_reg         <= IDX_W'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign bcd_digit     = digit_reg;
    assign display_index = index_reg;
    assign last_digit    = last_reg;

endmodule
`default_nettype wire
